FILE: design/bitmap_first_fit_allocator_top_assert.svh
// Assertion macros for the bitmap first-fit allocator.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_TOP_ASSERT_SVH
// Asserts that a condition implies a consequence in the same cycle.
`define BFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Asserts that a condition implies a consequence in the following cycle.
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/bffa_pkg.sv
// Shared types and constants of the bitmap first-fit allocator.
package bffa_pkg;
  localparam int UnitBytes  = 32;
  localparam int ArenaBytes = 65536;

  localparam logic [1:0] CmdAlloc  = 2'd0;
  localparam logic [1:0] CmdFree   = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadSize  = 3'd1;
  localparam logic [2:0] StNoSpace  = 3'd2;
  localparam logic [2:0] StBadAddr  = 3'd3;
  localparam logic [2:0] StNotAlloc = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] elem_count;
    logic [31:0] elem_bytes;
    logic [31:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload_offset;
    logic [16:0] used_bytes;
    logic [16:0] peak_bytes;
  } rsp_t;
endpackage

FILE: design/bitmap_first_fit_allocator_top.sv
// Top level of the bitmap first-fit allocator.
// An allocate multiplies the sizes, scans the units for a free run and marks that run;
// a free reads and checks the head unit, then releases its units; a clear rewrites every unit.
// Bad addresses and zero sizes answer from idle, an oversized product after the multiply.
// One item at a time: busy stays high through the strobe cycle; the receiver cannot stall.
// After reset a clearing pass over every unit runs with busy high and gives no result.
module bitmap_first_fit_allocator_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bffa_pkg::req_t  req_i,
  output logic            done_o,
  output bffa_pkg::rsp_t  rsp_o
);
  import bffa_pkg::*;

  localparam int NumUnits = ArenaBytes / UnitBytes;
  localparam int UW = $clog2(NumUnits);
  localparam int CW = UW + 1;
  localparam int SH = $clog2(UnitBytes);

  typedef enum logic [7:0] {
    SInit  = 8'b00000001,
    SIdle  = 8'b00000010,
    SMul   = 8'b00000100,
    SScan  = 8'b00001000,
    SMark  = 8'b00010000,
    SFreeR = 8'b00100000,
    SFreeC = 8'b01000000,
    SRel   = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0]  bits_q [NumUnits];
  logic [UW:0] len_q  [NumUnits];
  logic [1:0]  rd_q;
  logic [UW:0] len_rd_q;
  logic [UW-1:0] addr_q, addr_d, first_q, first_d;
  logic [CW-1:0] run_q, run_d, need_q, need_d;
  logic [16:0] used_q, used_d, peak_q, peak_d;
  logic [UW-1:0] wa;
  logic [1:0]  wd;
  logic        we, lwe, busy_q;
  logic        accept;
  logic        mul_start, mul_done;
  logic [63:0] prod;
  logic [63:0] need_w;
  logic [31:0] off;
  rsp_t        rsp_q, rsp_d;
  logic        done_q, done_d;

  bffa_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(req_i.elem_count),
    .b_i(req_i.elem_bytes), .done_o(mul_done), .prod_o(prod)
  );

  assign accept = start && !busy;
  assign off = req_i.free_offset;
  assign need_w = ((prod + 64'(UnitBytes - 1)) >> SH) + 64'd1;

  always_comb begin
    state_d = state_q;
    addr_d = addr_q;
    first_d = first_q;
    run_d = run_q;
    need_d = need_q;
    used_d = used_q;
    peak_d = peak_q;
    rsp_d = rsp_q;
    done_d = 1'b0;
    we = 1'b0;
    lwe = 1'b0;
    wa = addr_q;
    wd = 2'b00;
    mul_start = 1'b0;
    unique case (state_q)
      SInit: begin
        we = 1'b1;
        addr_d = addr_q + UW'(1);
        if (addr_q == UW'(NumUnits - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        addr_d = '0;
        if (accept) begin
          rsp_d = '{status: StOk, payload_offset: '0, used_bytes: used_q, peak_bytes: peak_q};
          case (req_i.command)
            CmdAlloc: begin
              if (req_i.elem_count == '0 || req_i.elem_bytes == '0) begin
                rsp_d.status = StBadSize;
                done_d = 1'b1;
              end else begin
                mul_start = 1'b1;
                state_d = SMul;
              end
            end
            CmdFree: begin
              if (off < 32'(UnitBytes) || off >= 32'(ArenaBytes)
                  || off[SH-1:0] != '0) begin
                rsp_d.status = StBadAddr;
                done_d = 1'b1;
              end else begin
                addr_d = UW'((off >> SH) - 32'd1);
                state_d = SFreeR;
              end
            end
            CmdClear: begin
              used_d = '0;
              peak_d = '0;
              rsp_d.used_bytes = '0;
              rsp_d.peak_bytes = '0;
              state_d = SInit;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      SMul: begin
        if (mul_done) begin
          if (prod > 64'(ArenaBytes - UnitBytes)) begin
            rsp_d.status = StBadSize;
            done_d = 1'b1;
            state_d = SIdle;
          end else begin
            need_d = CW'(need_w);
            run_d = '0;
            state_d = SScan;
          end
        end
      end
      SScan: begin
        // The registered read returns the occupancy of the unit at addr_q.
        if (rd_q[0]) begin
          run_d = '0;
        end else begin
          if (run_q == '0) begin
            first_d = addr_q;
          end
          run_d = run_q + CW'(1);
        end
        if (!rd_q[0] && run_d == need_q) begin
          addr_d = first_d;
          state_d = SMark;
        end else if (addr_q == UW'(NumUnits - 1)) begin
          rsp_d.status = StNoSpace;
          done_d = 1'b1;
          state_d = SIdle;
        end else begin
          addr_d = addr_q + UW'(1);
        end
      end
      SMark: begin
        we = 1'b1;
        wd = (addr_q == first_q) ? 2'b11 : 2'b01;
        lwe = (addr_q == first_q);
        addr_d = addr_q + UW'(1);
        if (CW'(addr_q - first_q) + CW'(1) == need_q) begin
          used_d = used_q + (17'(need_q) << SH);
          peak_d = (used_d > peak_q) ? used_d : peak_q;
          rsp_d.used_bytes = used_d;
          rsp_d.peak_bytes = peak_d;
          rsp_d.payload_offset = 16'((32'(first_q) + 32'd1) << SH);
          done_d = 1'b1;
          state_d = SIdle;
        end
      end
      SFreeR: state_d = SFreeC;
      SFreeC: begin
        if (!rd_q[1] || len_rd_q == '0
            || 32'(len_rd_q) > 32'(NumUnits) - 32'(addr_q)
            || 32'(used_q) < (32'(len_rd_q) << SH)) begin
          rsp_d.status = StNotAlloc;
          done_d = 1'b1;
          state_d = SIdle;
        end else begin
          first_d = addr_q;
          need_d = CW'(len_rd_q);
          state_d = SRel;
        end
      end
      SRel: begin
        we = 1'b1;
        addr_d = addr_q + UW'(1);
        if (CW'(addr_q - first_q) + CW'(1) == need_q) begin
          used_d = used_q - (17'(need_q) << SH);
          rsp_d.used_bytes = used_d;
          done_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    if (state_q == SInit && addr_q == UW'(NumUnits - 1)) begin
      done_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      addr_q <= '0;
      used_q <= '0;
      peak_q <= '0;
      done_q <= 1'b0;
      busy_q <= 1'b0;
      run_q <= '0;
    end else begin
      state_q <= state_d;
      addr_q <= addr_d;
      used_q <= used_d;
      peak_q <= peak_d;
      done_q <= done_d;
      busy_q <= (state_q == SIdle) ? (accept && req_i.command == CmdClear) : busy_q;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    need_q <= need_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      bits_q[wa] <= wd;
    end
    if (lwe) begin
      len_q[wa] <= need_q;
    end
    rd_q <= bits_q[addr_d];
    len_rd_q <= len_q[addr_d];
  end

  assign busy   = (state_q != SIdle) || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `include "bitmap_first_fit_allocator_top_assert.svh"
  `BFA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `BFA_ASSERT_IMP(a_peak_ge_used, done_o, rsp_o.peak_bytes >= rsp_o.used_bytes)
  `BFA_ASSERT_IMP(a_ok_payload, done_o && rsp_o.status != StOk, rsp_o.payload_offset == '0)
endmodule

FILE: design/bffa_mul.sv
// Sequential 32x32 multiplier, one 8-bit slice of the multiplier per cycle.
module bffa_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);
  logic [63:0] acc_q, acc_d;
  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [39:0] part;

  assign part = 40'(a_q) * 40'(b_q[7:0]);

  always_comb begin
    acc_d = acc_q;
    a_d = a_q;
    b_d = b_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_o = 1'b0;
    if (start_i) begin
      acc_d = '0;
      a_d = a_i;
      b_d = b_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = acc_q + ({24'd0, part} << {cnt_q[1:0], 3'd0});
      b_d = b_q >> 8;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd3) begin
        run_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign prod_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end
endmodule

FILE: bench/bitmap_first_fit_allocator_top_tb.sv
// Self-checking testbench of the bitmap first-fit allocator top level.
module bitmap_first_fit_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bffa_pkg::*;

  localparam int NumUnits   = ArenaBytes / UnitBytes;
  localparam int RandItems  = 830;
  localparam int StallLimit = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  bitmap_first_fit_allocator_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the arena.
  bit          unit_taken [NumUnits];
  bit          head_mark  [NumUnits];
  logic [11:0] run_len    [NumUnits];
  logic [16:0] used_now;
  logic [16:0] used_peak;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } vec_t;

  vec_t        plan[$];
  rsp_t        pending_rsp[$];
  logic [31:0] live_offsets[$];
  int          mismatches, items_sent, results_seen;
  int          grants, releases, no_space_hits, clears;
  int          idle_pct;
  int          stall_cycles;

  function automatic void wipe_arena();
    foreach (unit_taken[k]) begin
      unit_taken[k] = 1'b0;
      head_mark[k]  = 1'b0;
      run_len[k]    = '0;
    end
    used_now  = '0;
    used_peak = '0;
  endfunction

  // Computes the result of one item and updates the shadow arena.
  function automatic rsp_t allocator_step(req_t r);
    rsp_t        o;
    logic [63:0] prod;
    logic [63:0] need;
    int          first, run, at, n;
    o = '0;
    first = 0;
    run = 0;
    case (r.command)
      CmdAlloc: begin
        prod = {32'd0, r.elem_count} * {32'd0, r.elem_bytes};
        if (r.elem_count == 0 || r.elem_bytes == 0 || prod > ArenaBytes - UnitBytes) begin
          o.status = StBadSize;
        end else begin
          need = (prod + UnitBytes - 1) / UnitBytes + 1;
          o.status = StNoSpace;
          for (int k = 0; k < NumUnits; k++) begin
            if (unit_taken[k]) begin
              run = 0;
            end else begin
              if (run == 0) first = k;
              run++;
              if (run == need) begin
                for (int j = first; j < first + run; j++) unit_taken[j] = 1'b1;
                head_mark[first] = 1'b1;
                run_len[first] = 12'(run);
                used_now = used_now + 17'(run * UnitBytes);
                if (used_now > used_peak) used_peak = used_now;
                o.status = StOk;
                o.payload_offset = 16'((first + 1) * UnitBytes);
                break;
              end
            end
          end
        end
      end
      CmdFree: begin
        if (r.free_offset < UnitBytes || r.free_offset >= ArenaBytes ||
            r.free_offset % UnitBytes != 0) begin
          o.status = StBadAddr;
        end else begin
          at = r.free_offset / UnitBytes - 1;
          n  = head_mark[at] ? int'(run_len[at]) : 0;
          if (!head_mark[at] || n == 0 || n > NumUnits - at || used_now < n * UnitBytes) begin
            o.status = StNotAlloc;
          end else begin
            for (int j = at; j < at + n; j++) begin
              unit_taken[j] = 1'b0;
              head_mark[j]  = 1'b0;
            end
            used_now = used_now - 17'(n * UnitBytes);
          end
        end
      end
      CmdClear: wipe_arena();
      default: ;
    endcase
    o.used_bytes = used_now;
    o.peak_bytes = used_peak;
    return o;
  endfunction

  task automatic row(logic [1:0] cmd, logic [31:0] cnt, logic [31:0] bytes_each,
                     logic [31:0] off, bit typed, logic [2:0] st, logic [15:0] pay,
                     logic [16:0] used, logic [16:0] peak);
    vec_t v;
    v.req   = '{command: cmd, elem_count: cnt, elem_bytes: bytes_each, free_offset: off};
    v.typed = typed;
    v.rsp   = '{status: st, payload_offset: pay, used_bytes: used, peak_bytes: peak};
    plan.push_back(v);
  endtask

  // Drives one item, waits for it to be taken, then records what it should return.
  task automatic send(vec_t v);
    int   gap;
    rsp_t want;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= v.req;
    do @(posedge clk_i); while (busy);
    items_sent++;
    want = allocator_step(v.req);
    if (v.typed) want = v.rsp;
    pending_rsp.push_back(want);
    if (v.req.command == CmdClear) begin
      live_offsets.delete();
      clears++;
    end
    if (want.status == StNoSpace) no_space_hits++;
    if (want.status == StOk && v.req.command == CmdAlloc) begin
      live_offsets.push_back(32'(want.payload_offset));
      grants++;
    end
    if (want.status == StOk && v.req.command == CmdFree) begin
      releases++;
      foreach (live_offsets[i]) begin
        if (live_offsets[i] == v.req.free_offset) begin
          live_offsets.delete(i);
          break;
        end
      end
    end
  endtask

  function automatic vec_t random_item();
    vec_t v;
    int   pick;
    v.typed = 1'b0;
    v.rsp   = '0;
    v.req   = '0;
    pick = $urandom_range(99);
    if (live_offsets.size() > 40 && pick < 50) pick = 60;
    if (pick < 45 || (pick < 80 && live_offsets.size() == 0)) begin
      v.req.command = CmdAlloc;
      if ($urandom_range(19) == 0) begin
        v.req.elem_count = 1;
        v.req.elem_bytes = $urandom_range(8000, 1);
      end else begin
        v.req.elem_count = $urandom_range(8, 1);
        v.req.elem_bytes = $urandom_range(64, 1);
      end
    end else if (pick < 80) begin
      v.req.command     = CmdFree;
      v.req.free_offset = live_offsets[$urandom_range(live_offsets.size() - 1)];
    end else if (pick < 86) begin
      // Aligned offsets that are mostly not block heads, double frees among them.
      v.req.command     = CmdFree;
      v.req.free_offset = UnitBytes * $urandom_range(NumUnits - 1, 1);
    end else if (pick < 91) begin
      v.req.command     = CmdFree;
      v.req.free_offset = $urandom;
    end else if (pick < 96) begin
      v.req.command    = CmdAlloc;
      v.req.elem_count = $urandom;
      v.req.elem_bytes = $urandom;
      if ($urandom_range(1)) v.req.elem_count = $urandom_range(3);
    end else if (pick < 98) begin
      v.req.command    = CmdClear;
      v.req.elem_count = $urandom;
      v.req.elem_bytes = $urandom;
    end else begin
      v.req.command     = CmdUnused;
      v.req.free_offset = $urandom;
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp_o);
      end else begin
        rsp_t want;
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status || rsp_o.payload_offset !== want.payload_offset ||
            rsp_o.used_bytes !== want.used_bytes || rsp_o.peak_bytes !== want.peak_bytes) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d: expected %p, got %p",
                                         results_seen, want, rsp_o);
        end
      end
    end
  end

  // Ends the run if neither an item nor a result moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog expired with %0d results outstanding", pending_rsp.size());
        $display("bitmap_first_fit_allocator_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int phase_pct[4];
    phase_pct = '{0, 56, 0, 36};
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    grants = 0;
    releases = 0;
    no_space_hits = 0;
    clears = 0;
    stall_cycles = 0;
    idle_pct = 0;
    wipe_arena();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    row(CmdAlloc, 0, 5, 0, 1, StBadSize, 0, 0, 0);
    row(CmdAlloc, 7, 0, 0, 1, StBadSize, 0, 0, 0);
    row(CmdAlloc, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, StBadSize, 0, 0, 0);
    row(CmdAlloc, 1, 65505, 0, 1, StBadSize, 0, 0, 0);
    row(CmdAlloc, 1, 65504, 0, 1, StOk, 32, 65536, 65536);
    row(CmdAlloc, 1, 1, 0, 1, StNoSpace, 0, 65536, 65536);
    row(CmdFree, 0, 0, 32, 1, StOk, 0, 0, 65536);
    row(CmdFree, 0, 0, 32, 1, StNotAlloc, 0, 0, 65536);
    row(CmdFree, 0, 0, 16, 1, StBadAddr, 0, 0, 65536);
    row(CmdFree, 0, 0, 65536, 1, StBadAddr, 0, 0, 65536);
    row(CmdFree, 0, 0, 33, 1, StBadAddr, 0, 0, 65536);
    row(CmdFree, 0, 0, 0, 1, StBadAddr, 0, 0, 65536);
    row(CmdFree, 0, 0, 32'hFFFF_FFFF, 1, StBadAddr, 0, 0, 65536);
    row(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, StOk, 0, 0, 65536);
    row(CmdClear, 0, 0, 0, 1, StOk, 0, 0, 0);
    row(CmdAlloc, 1, 1, 0, 1, StOk, 32, 64, 64);
    row(CmdAlloc, 2, 32, 0, 1, StOk, 96, 160, 160);
    row(CmdFree, 0, 0, 32, 1, StOk, 0, 96, 160);
    row(CmdAlloc, 1, 32, 0, 1, StOk, 32, 160, 160);
    row(CmdAlloc, 3, 100, 0, 0, 0, 0, 0, 0);
    row(CmdFree, 0, 0, 96, 0, 0, 0, 0, 0);
    row(CmdFree, 0, 0, 65504, 0, 0, 0, 0, 0);
    row(CmdAlloc, 65535, 2, 0, 0, 0, 0, 0, 0);
    row(CmdClear, 0, 0, 0, 0, 0, 0, 0, 0);
    foreach (plan[i]) send(plan[i]);

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (int i = 0; i < RandItems / 4; i++) send(random_item());
    end
    start <= 1'b0;

    wait (pending_rsp.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d items sent, %0d results checked, %0d mismatches", items_sent, results_seen,
             mismatches);
    $display("%0d grants, %0d releases, %0d full-arena refusals, %0d clears", grants, releases,
             no_space_hits, clears);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("bitmap_first_fit_allocator_top regression: pass");
    end else begin
      $display("bitmap_first_fit_allocator_top regression: fail");
    end
    $finish;
  end
endmodule
